[design/fft_pkg.sv]
// shared types, constants and twiddle tables for the 64-point fft
`timescale 1ns / 1ps
`default_nettype none
package fft_pkg;
  localparam int POINTS_DEF = 64;
  localparam int DATA_W = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BFLY,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // cos(2*pi*k/64) in q15
  function automatic logic signed [15:0] tw_cos(input logic [4:0] k);
    logic signed [15:0] v;
    case (k)
      5'd0: v = 16'sd32767;   5'd1: v = 16'sd32609;   5'd2: v = 16'sd32137;
      5'd3: v = 16'sd31356;   5'd4: v = 16'sd30273;   5'd5: v = 16'sd28898;
      5'd6: v = 16'sd27245;   5'd7: v = 16'sd25329;   5'd8: v = 16'sd23170;
      5'd9: v = 16'sd20787;   5'd10: v = 16'sd18204;  5'd11: v = 16'sd15446;
      5'd12: v = 16'sd12539;  5'd13: v = 16'sd9512;   5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;   5'd16: v = 16'sd0;      5'd17: v = -16'sd3212;
      5'd18: v = -16'sd6393;  5'd19: v = -16'sd9512;  5'd20: v = -16'sd12539;
      5'd21: v = -16'sd15446; 5'd22: v = -16'sd18204; 5'd23: v = -16'sd20787;
      5'd24: v = -16'sd23170; 5'd25: v = -16'sd25329; 5'd26: v = -16'sd27245;
      5'd27: v = -16'sd28898; 5'd28: v = -16'sd30273; 5'd29: v = -16'sd31356;
      5'd30: v = -16'sd32137; 5'd31: v = -16'sd32609;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // -sin(2*pi*k/64) in q15, equals cos of k+16 with the 32767 end
  function automatic logic signed [15:0] tw_sin(input logic [4:0] k);
    logic signed [15:0] v;
    if (k == 5'd0) v = 16'sd0;
    else if (k == 5'd16) v = -16'sd32767;
    else if (k < 5'd16) v = -tw_cos(5'd16 - k);
    else v = -tw_cos(k - 5'd16);
    return v;
  endfunction

  // saturate a rounded product to int16
  function automatic logic signed [15:0] sat16(input logic signed [33:0] a);
    logic signed [18:0] r;
    r = 19'(a >>> 15);
    if (r > 19'sd32767) return 16'sh7fff;
    if (r < -19'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction
endpackage
`default_nettype wire

[design/fft_ram.sv]
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/fft_bfly.sv]
// pipelined radix-2 butterfly: multiply, round, add and halve
`timescale 1ns / 1ps
`default_nettype none
module fft_bfly (
  input  wire logic        clk,
  input  wire logic [31:0] a_in,
  input  wire logic [31:0] b_in,
  input  wire logic [4:0]  tw_idx,
  output logic      [31:0] lo_out,
  output logic      [31:0] hi_out
);
  logic signed [15:0] br, bi, wr, wi;
  logic signed [31:0] m_rr_r, m_ii_r, m_ri_r, m_ir_r;
  logic [31:0]        a_r;
  logic signed [15:0] pr, pi, ar, ai;
  logic signed [16:0] sr, si, dr, di;

  assign br = b_in[31:16];
  assign bi = b_in[15:0];
  assign wr = fft_pkg::tw_cos(tw_idx);
  assign wi = fft_pkg::tw_sin(tw_idx);

  // stage one: four products
  always_ff @(posedge clk) begin
    m_rr_r <= br * wr;
    m_ii_r <= bi * wi;
    m_ri_r <= br * wi;
    m_ir_r <= bi * wr;
    a_r    <= a_in;
  end

  // stage two: round, saturate, sum and difference halved
  assign pr = fft_pkg::sat16(34'(m_rr_r) - 34'(m_ii_r) + 34'sd16384);
  assign pi = fft_pkg::sat16(34'(m_ri_r) + 34'(m_ir_r) + 34'sd16384);
  assign ar = a_r[31:16];
  assign ai = a_r[15:0];
  assign sr = 17'(ar) + 17'(pr);
  assign si = 17'(ai) + 17'(pi);
  assign dr = 17'(ar) - 17'(pr);
  assign di = 17'(ai) - 17'(pi);
  assign lo_out = {sr[16:1], si[16:1]};
  assign hi_out = {dr[16:1], di[16:1]};
endmodule
`default_nettype wire

[design/fft64_fixed_point_top.sv]
// 64-point q15 radix-2 dit fft: load, in-place butterflies, unload
//
// channel  | ports                          | direction
// input    | start, busy, in_sample_re/im   | in, busy back
// result   | out_valid, out_bin_re/im/last  | out, no backpressure
//
// loading accepts one item whenever start is high and busy is low; the 64th item
// starts 6 stages of 32 butterflies on the single data ram, then the drain,
// 64 output reads and the read and output registers, with busy held high
// until the last bin has left.
// the 64 bins leave back to back; the receiver cannot stall them.
// rst_n is synchronous and clears the control state; the ram holds no reset.
// the bit reversal is done on the write address while loading.
`timescale 1ns / 1ps
`default_nettype none
module fft64_fixed_point_top #(
  parameter int POINTS = fft_pkg::POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_sample_re,
  input  wire logic [15:0] in_sample_im,
  output logic             out_valid,
  output logic [15:0]      out_bin_re,
  output logic [15:0]      out_bin_im,
  output logic             out_last_bin
);
  localparam int AW = $clog2(POINTS);

  fft_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;      // load position / butterfly / out index
  logic [2:0]    stg_r, stg_nxt;      // stage 0..5
  logic [1:0]    ph_r, ph_nxt;        // butterfly phase
  logic [31:0]   a_r;
  logic [31:0]   lo_w, hi_w;

  logic          we;
  logic [AW-1:0] waddr, raddr, lo_addr, hi_addr, rev;
  logic [31:0]   wdata, rdata;
  logic          ov_r, oa_r, olast_r;
  logic [4:0]    tw_nxt;
  logic [AW-1:0] jmask;
  logic          acc;

  logic          hold_v_r;
  logic [AW-1:0] hold_a_r;
  logic [31:0]   hold_d_r;

  fft_ram #(.WIDTH(32), .DEPTH(POINTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  fft_bfly u_bfly (
    .clk, .a_in(a_r), .b_in(rdata), .tw_idx(tw_nxt), .lo_out(lo_w), .hi_out(hi_w)
  );

  // input item accepted
  assign acc = start & ~busy;

  // bit-reversed load address
  always_comb begin
    for (int i = 0; i < AW; i++) rev[i] = cnt_r[AW-1-i];
  end

  // butterfly addresses: insert a zero at bit stg of the counter
  always_comb begin
    jmask   = AW'((1 << stg_r) - 1);
    lo_addr = ((cnt_r & ~jmask) << 1) | (cnt_r & jmask);
    hi_addr = lo_addr | AW'(1 << stg_r);
    tw_nxt  = 5'((cnt_r & jmask) << (AW - 1 - stg_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    stg_nxt   = stg_r;
    ph_nxt    = ph_r;
    case (state_r)
      fft_pkg::ST_LOAD: begin
        if (acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == AW'(POINTS - 1)) begin
            state_nxt = fft_pkg::ST_BFLY;
            stg_nxt   = '0;
            ph_nxt    = '0;
          end
        end
      end
      fft_pkg::ST_BFLY: begin
        ph_nxt = ph_r + 1'b1;
        if (ph_r == 2'd3) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == AW'(POINTS / 2 - 1)) begin
            cnt_nxt = '0;
            if (stg_r == 3'(AW - 1)) state_nxt = fft_pkg::ST_DRAIN;
            else stg_nxt = stg_r + 1'b1;
          end
        end
      end
      fft_pkg::ST_DRAIN: begin
        ph_nxt = ph_r + 1'b1;
        if (ph_r == 2'd1) begin
          state_nxt = fft_pkg::ST_OUT;
          cnt_nxt   = '0;
        end
      end
      fft_pkg::ST_OUT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AW'(POINTS - 1)) state_nxt = fft_pkg::ST_LOAD;
      end
      default: state_nxt = fft_pkg::ST_LOAD;
    endcase
  end

  // ram port control
  // phase 0 read lo, 1 read hi / capture lo, 2 hi into the multipliers,
  // 3 write lo; hi of this butterfly is written at phase 0 of the next one
  // (or drain 0)
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = lo_addr;
    case (state_r)
      fft_pkg::ST_LOAD: begin
        we    = acc;
        waddr = rev;
        wdata = {in_sample_re, in_sample_im};
      end
      fft_pkg::ST_BFLY: begin
        if (ph_r == 2'd1) raddr = hi_addr;
        if (ph_r == 2'd0 && hold_v_r) begin
          we = 1'b1; waddr = hold_a_r; wdata = hold_d_r;
        end
        if (ph_r == 2'd3) begin
          we = 1'b1; waddr = lo_addr; wdata = lo_w;
        end
      end
      fft_pkg::ST_DRAIN: begin
        if (ph_r == 2'd0 && hold_v_r) begin
          we = 1'b1; waddr = hold_a_r; wdata = hold_d_r;
        end
      end
      fft_pkg::ST_OUT: raddr = cnt_r;
      default: ;
    endcase
  end

  // butterfly operand capture and pending hi write
  always_ff @(posedge clk) begin
    if (state_r == fft_pkg::ST_BFLY) begin
      if (ph_r == 2'd1) a_r <= rdata;
      if (ph_r == 2'd3) begin
        hold_a_r <= hi_addr;
        hold_d_r <= hi_w;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fft_pkg::ST_LOAD;
      cnt_r    <= '0;
      stg_r    <= '0;
      ph_r     <= '0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
      oa_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      stg_r   <= stg_nxt;
      ph_r    <= ph_nxt;
      if (state_r == fft_pkg::ST_BFLY && ph_r == 2'd3) hold_v_r <= 1'b1;
      else if (ph_r == 2'd0) hold_v_r <= 1'b0;
      oa_r <= (state_r == fft_pkg::ST_OUT);
      ov_r <= oa_r;
    end
  end

  // output index pipeline matching read latency
  logic olast_a_r;
  always_ff @(posedge clk) begin
    olast_a_r <= (state_r == fft_pkg::ST_OUT) && (cnt_r == AW'(POINTS - 1));
    olast_r   <= olast_a_r;
    out_bin_re <= rdata[31:16];
    out_bin_im <= rdata[15:0];
  end

  assign busy         = (state_r != fft_pkg::ST_LOAD) || oa_r || ov_r;
  assign out_valid    = ov_r;
  assign out_last_bin = olast_r & ov_r;
endmodule
`default_nettype wire

[tb/fft64_fixed_point_top_tb.sv]
// testbench for the 64-point q15 fft: frame stimulus, bin-by-bin prediction and checking
`timescale 1ns / 1ps
module fft64_fixed_point_top_tb;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
  } sample_t;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic        last;
  } bin_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_sample_re;
  logic [15:0] in_sample_im;
  logic        out_valid;
  logic [15:0] out_bin_re;
  logic [15:0] out_bin_im;
  logic        out_last_bin;

  sample_t pending_samples[$];
  bin_t    expected_bins[$];
  sample_t frame_buf[64];
  int      frame_fill;
  int      fail_count;
  int      bins_seen;
  int      frames_done;
  int      idle_pct;
  bit      accepted;

  fft64_fixed_point_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_re(in_sample_re), .in_sample_im(in_sample_im),
    .out_valid(out_valid), .out_bin_re(out_bin_re), .out_bin_im(out_bin_im),
    .out_last_bin(out_last_bin)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // q15 twiddle table, cos - j sin
  function automatic int twid_re(input int k);
    int tab[32] = '{32767, 32609, 32137, 31356, 30273, 28898, 27245, 25329,
                    23170, 20787, 18204, 15446, 12539, 9512, 6393, 3212,
                    0, -3212, -6393, -9512, -12539, -15446, -18204, -20787,
                    -23170, -25329, -27245, -28898, -30273, -31356, -32137, -32609};
    return tab[k];
  endfunction

  // -sin(2 pi k / 64) in q15, via the cos quarter shift
  function automatic int sin_q15(input int k);
    if (k == 0) return 0;
    if (k <= 16) return -twid_re(16 - k);
    return -twid_re(k - 16);
  endfunction

  // round a q30 product to q15 with saturation
  function automatic int round_sat(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  // scaled dit fft of the collected frame, pushes 64 expected bins
  task automatic predict_frame();
    int     bre[64];
    int     bim[64];
    int     rv, span, half, stp, t, lo, hi, ar, ai, br, bi, wr, wi, pr, pi;
    bin_t   b;
    for (int i = 0; i < 64; i++) begin
      rv = 0;
      for (int q = 0; q < 6; q++) if (i[q]) rv |= 1 << (5 - q);
      bre[i] = $signed(frame_buf[rv].re);
      bim[i] = $signed(frame_buf[rv].im);
    end
    for (int s = 1; s <= 6; s++) begin
      span = 1 << s;
      half = span >> 1;
      stp = 64 / span;
      for (int k = 0; k < 64; k += span) begin
        for (int j = 0; j < half; j++) begin
          t = (j * stp) & 31;
          lo = k + j;
          hi = k + j + half;
          ar = bre[lo]; ai = bim[lo]; br = bre[hi]; bi = bim[hi];
          wr = twid_re(t); wi = sin_q15(t);
          pr = round_sat(longint'(br) * wr - longint'(bi) * wi);
          pi = round_sat(longint'(br) * wi + longint'(bi) * wr);
          bre[lo] = (ar + pr) >>> 1;
          bim[lo] = (ai + pi) >>> 1;
          bre[hi] = (ar - pr) >>> 1;
          bim[hi] = (ai - pi) >>> 1;
        end
      end
    end
    for (int i = 0; i < 64; i++) begin
      b.re = bre[i][15:0];
      b.im = bim[i][15:0];
      b.last = (i == 63);
      expected_bins.push_back(b);
    end
  endtask

  // driver: one item offered per cycle, with random gaps; an item is offered again until it is accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (accepted) void'(pending_samples.pop_front());
      if (pending_samples.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        start <= 1'b1;
        in_sample_re <= pending_samples[0].re;
        in_sample_im <= pending_samples[0].im;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // accepted items feed the predictor
  always @(posedge clk) begin
    accepted = rst_n && start && !busy;
    if (accepted) begin
      frame_buf[frame_fill] = '{in_sample_re, in_sample_im};
      frame_fill = frame_fill + 1;
      if (frame_fill == 64) begin
        frame_fill = 0;
        predict_frame();
      end
    end
  end

  // monitor: compare each bin against the oldest expectation
  always @(posedge clk) begin
    bin_t e;
    if (rst_n && out_valid) begin
      bins_seen++;
      if (expected_bins.size() == 0) begin
        $error("unexpected bin re=%0d im=%0d", $signed(out_bin_re), $signed(out_bin_im));
        fail_count++;
      end else begin
        e = expected_bins.pop_front();
        if (out_bin_re !== e.re) begin
          $error("bin_re expected %0d got %0d", $signed(e.re), $signed(out_bin_re));
          fail_count++;
        end
        if (out_bin_im !== e.im) begin
          $error("bin_im expected %0d got %0d", $signed(e.im), $signed(out_bin_im));
          fail_count++;
        end
        if (out_last_bin !== e.last) begin
          $error("last_bin expected %0d got %0d", e.last, out_last_bin);
          fail_count++;
        end
        if (e.last) frames_done++;
      end
    end
  end

  // queue one frame of 64 items
  task automatic add_frame(input int kind);
    sample_t s;
    for (int i = 0; i < 64; i++) begin
      case (kind)
        0: s = '{16'h7fff, 16'h8000};
        1: s = (i == 0) ? '{16'h7fff, 16'h7fff} : '{16'h0000, 16'h0000};
        2: s = (i[0]) ? '{16'h8000, 16'h8000} : '{16'h7fff, 16'h7fff};
        3: s = '{16'($urandom), 16'($urandom)};
        4: s = '{16'($urandom_range(255, 0) - 128), 16'($urandom_range(255, 0) - 128)};
        default: s = '{16'(twid_re((i * 3) % 32)), 16'(sin_q15((i * 3) % 32))};
      endcase
      pending_samples.push_back(s);
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_bins.size() > 0) @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_sample_re = '0;
    in_sample_im = '0;
    frame_fill = 0;
    fail_count = 0;
    bins_seen = 0;
    frames_done = 0;
    accepted = 1'b0;
    idle_pct = 38;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // alternating extremes with the sender idling now and then
    add_frame(2);
    wait_drained();
    // tone frame with the sender idling often
    idle_pct = 70;
    add_frame(5);
    wait_drained();
    // random full-scale frame back to back
    idle_pct = 0;
    add_frame(3);
    wait_drained();
    repeat (400) @(posedge clk);
    $display("covered %0d fft frames, %0d bins checked", frames_done, bins_seen);
    $display("alternating extremes, a twiddle tone and a random full-scale frame");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
